// ===== hdl/lrsa_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, control types and helpers for the logrank score accumulator.
// No dependencies; every module of the block imports this package.
package lrsa_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int FIELD_W = 16;   // width of each count field on the input bus
  localparam int CAP_W   = 60;   // E and variance terms clamp at 2^CAP_W-1
  localparam int SCORE_W = 48;   // score width, also its clamp
  localparam int ACC_W   = 48;   // z and v accumulator width
  localparam int MUL_W   = 64;   // multiplier operand width
  localparam int HALF_W  = 32;   // partial product operand width
  localparam int PROD_W  = 128;  // full product width
  localparam int NBITS_W = 8;    // divider step count width

  typedef struct packed {
    logic               start;
    logic               cap48;   // clamp quotient at SCORE_W bits instead of CAP_W
    logic [NBITS_W-1:0] nbits;   // dividend bits to walk, from the top
  } div_ctl_t;

  function automatic int lrsa_max(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ===== hdl/lrsa_mul.sv =====
`timescale 1ns / 1ps
// Shared 64x64 multiplier built from one 32x32 product per cycle and an accumulator.
// Depends on lrsa_pkg.
module lrsa_mul import lrsa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MUL_W-1:0]  op_a,
  input  logic [MUL_W-1:0]  op_b,
  output logic              done,
  output logic [PROD_W-1:0] prod
);

  logic [MUL_W-1:0]  a_r, a_nxt;
  logic [MUL_W-1:0]  b_r, b_nxt;
  logic [1:0]        k_r, k_nxt;
  logic              iss_r, iss_nxt;
  logic [MUL_W-1:0]  pp_r, pp_nxt;
  logic [1:0]        sh_r, sh_nxt;
  logic              ppv_r, ppv_nxt;
  logic              ppl_r, ppl_nxt;
  logic [PROD_W-1:0] acc_r, acc_nxt;
  logic              done_r, done_nxt;

  logic [HALF_W-1:0] ah, bh;
  logic [PROD_W-1:0] pp_sh;

  assign ah = k_r[1] ? a_r[MUL_W-1:HALF_W] : a_r[HALF_W-1:0];
  assign bh = k_r[0] ? b_r[MUL_W-1:HALF_W] : b_r[HALF_W-1:0];

  always_comb begin
    case (sh_r)
      2'd0: pp_sh = PROD_W'(pp_r);
      2'd1: pp_sh = {{HALF_W{1'b0}}, pp_r, {HALF_W{1'b0}}};
      2'd2: pp_sh = {pp_r, {MUL_W{1'b0}}};
      default: pp_sh = '0;
    endcase
  end

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    k_nxt    = k_r;
    iss_nxt  = iss_r;
    pp_nxt   = pp_r;
    sh_nxt   = sh_r;
    ppv_nxt  = 1'b0;
    ppl_nxt  = 1'b0;
    acc_nxt  = acc_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt   = op_a;
      b_nxt   = op_b;
      k_nxt   = '0;
      iss_nxt = 1'b1;
      acc_nxt = '0;
    end else begin
      // issue one partial product per cycle
      if (iss_r) begin
        pp_nxt  = MUL_W'(ah) * MUL_W'(bh);
        sh_nxt  = {1'b0, k_r[1]} + {1'b0, k_r[0]};
        ppv_nxt = 1'b1;
        ppl_nxt = (k_r == 2'd3);
        k_nxt   = k_r + 2'd1;
        if (k_r == 2'd3) begin
          iss_nxt = 1'b0;
        end
      end
      // fold the registered partial product into the sum
      if (ppv_r) begin
        acc_nxt = acc_r + pp_sh;
        if (ppl_r) begin
          done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r    <= '0;
      iss_r  <= 1'b0;
      ppv_r  <= 1'b0;
      ppl_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      k_r    <= k_nxt;
      iss_r  <= iss_nxt;
      ppv_r  <= ppv_nxt;
      ppl_r  <= ppl_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    pp_r  <= pp_nxt;
    sh_r  <= sh_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ===== hdl/lrsa_div.sv =====
`timescale 1ns / 1ps
// Shared restoring divider, one quotient bit per cycle, with a clamped quotient.
// Depends on lrsa_pkg.
module lrsa_div import lrsa_pkg::*; #(
  parameter int DW = 96,
  parameter int VW = 48
) (
  input  logic             clk,
  input  logic             rst_n,
  input  div_ctl_t         ctl,
  input  logic [DW-1:0]    dividend,
  input  logic [VW-1:0]    divisor,
  output logic             done,
  output logic [CAP_W-1:0] quo
);

  localparam int QW = CAP_W + 1;
  localparam int IW = $clog2(DW);

  logic [DW-1:0] dvd_r, dvd_nxt;
  logic [VW-1:0] dvs_r, dvs_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic          ovf_r, ovf_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt;
  logic          cap48_r, cap48_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;

  logic [VW:0]        rem_sh;
  logic [VW:0]        diff;
  logic               ge;
  logic [NBITS_W-1:0] nbits_m1;
  logic               sat60, sat48;

  assign rem_sh   = {rem_r, dvd_r[cnt_r]};
  assign diff     = rem_sh - {1'b0, dvs_r};
  assign ge       = (rem_sh >= {1'b0, dvs_r});
  assign nbits_m1 = ctl.nbits - NBITS_W'(1);

  always_comb begin
    dvd_nxt   = dvd_r;
    dvs_nxt   = dvs_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    ovf_nxt   = ovf_r;
    cnt_nxt   = cnt_r;
    cap48_nxt = cap48_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (ctl.start) begin
      dvd_nxt   = dividend;
      dvs_nxt   = divisor;
      rem_nxt   = '0;
      q_nxt     = '0;
      ovf_nxt   = 1'b0;
      cnt_nxt   = nbits_m1[IW-1:0];
      cap48_nxt = ctl.cap48;
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[VW-1:0] : rem_sh[VW-1:0];
      q_nxt   = {q_r[QW-2:0], ge};
      // a set bit leaving the quotient register means it is past any clamp
      ovf_nxt = ovf_r | q_r[QW-1];
      cnt_nxt = cnt_r - IW'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r   <= dvd_nxt;
    dvs_r   <= dvs_nxt;
    rem_r   <= rem_nxt;
    q_r     <= q_nxt;
    ovf_r   <= ovf_nxt;
    cnt_r   <= cnt_nxt;
    cap48_r <= cap48_nxt;
  end

  assign sat60 = ovf_r | q_r[CAP_W];
  assign sat48 = ovf_r | (|q_r[CAP_W:SCORE_W]);

  always_comb begin
    if (cap48_r) begin
      quo = sat48 ? CAP_W'({SCORE_W{1'b1}}) : CAP_W'(q_r[SCORE_W-1:0]);
    end else begin
      quo = sat60 ? {CAP_W{1'b1}} : q_r[CAP_W-1:0];
    end
  end

  assign done = done_r;

endmodule

// ===== hdl/logrank_score_accumulator_core.sv =====
`timescale 1ns / 1ps
// Two-sample logrank score accumulator: one failure time point per input transaction,
// score Z*Z/V on the point marked with tlast. A sequencer drives the shared
// multiplier and divider one step at a time. Depends on lrsa_pkg, lrsa_mul, lrsa_div.
//
// Input channel in_*: one transaction per time point; tlast marks the final point.
// Output channel out_*: one transaction per final point, score in tdata, the
// variance-positive flag in tuser. Other points produce no output.
// Work per point: a point with zero at risk runs one product before the update;
// at risk of one adds the E division; a regular point also runs the variance
// products and the term division. The final point adds the Z*Z product and
// score division (skipped when the variance is zero), and skips its own term
// when its failures are one or less. The divider is radix-2 (one quotient bit
// per cycle) and the multiplier takes four 32x32 partial products per product.
// in_tready is high only while the sequencer is idle; one point is in flight.
// The result sits in an output register, so the next point is accepted while
// a score waits; if the receiver still stalls when the next score is ready,
// the sequencer holds that score until the register frees.
// Reset clears the accumulators, the sequencer and out_tvalid.
module logrank_score_accumulator_core import lrsa_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [4*FIELD_W-1:0] in_tdata,   // total_events, total_at_risk, left_events, left_at_risk
  input  logic                 in_tlast,   // last_point
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [SCORE_W-1:0]   out_tdata,  // score
  output logic [0:0]           out_tuser   // score_valid
);

  localparam int CW    = COUNT_BITS;
  localparam int FB    = FRAC_BITS;
  localparam int PW    = 2 * CW;
  localparam int E_DW  = PW + FB;
  localparam int DW    = lrsa_max(CAP_W + PW, 2 * SCORE_W);
  localparam int VW    = lrsa_max(PW, ACC_W);
  localparam int XW    = FIELD_W + CW;
  localparam int SUM_W = 64;

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_MOR  = 12'b0000_0000_0010,
    S_DE   = 12'b0000_0000_0100,
    S_MNN  = 12'b0000_0000_1000,
    S_MFF  = 12'b0000_0001_0000,
    S_MEF  = 12'b0000_0010_0000,
    S_DT   = 12'b0000_0100_0000,
    S_UPD  = 12'b0000_1000_0000,
    S_FIN  = 12'b0001_0000_0000,
    S_MZZ  = 12'b0010_0000_0000,
    S_DS   = 12'b0100_0000_0000,
    S_EMIT = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   launched_r, launched_nxt;

  logic [CW-1:0]    o_r, o_nxt;
  logic [CW-1:0]    n_r, n_nxt;
  logic [CW-1:0]    l_r, l_nxt;
  logic [CW-1:0]    r_r, r_nxt;
  logic             last_r, last_nxt;
  logic [CAP_W-1:0] e_r, e_nxt;
  logic [PW-1:0]    nn_r, nn_nxt;
  logic [PW-1:0]    ff_r, ff_nxt;
  logic [ACC_W-1:0] z_r, z_nxt;
  logic [ACC_W-1:0] v_r, v_nxt;
  logic             zv_r, zv_nxt;

  logic               out_tvalid_r, out_tvalid_nxt;
  logic [SCORE_W-1:0] out_tdata_r, out_tdata_nxt;
  logic               out_tuser_r, out_tuser_nxt;

  // input fields taken in their low CW bits
  logic [XW-1:0] o_x, n_x, l_x, r_x;
  logic [CW-1:0] o_in, n_in, l_in, r_in;

  assign o_x  = {{CW{1'b0}}, in_tdata[FIELD_W-1:0]};
  assign n_x  = {{CW{1'b0}}, in_tdata[2*FIELD_W-1:FIELD_W]};
  assign l_x  = {{CW{1'b0}}, in_tdata[3*FIELD_W-1:2*FIELD_W]};
  assign r_x  = {{CW{1'b0}}, in_tdata[4*FIELD_W-1:3*FIELD_W]};
  assign o_in = o_x[CW-1:0];
  assign n_in = n_x[CW-1:0];
  assign l_in = l_x[CW-1:0];
  assign r_in = r_x[CW-1:0];

  // shared units
  logic              mul_start, mul_done;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] mul_prod;
  div_ctl_t          div_ctl;
  logic [DW-1:0]     div_dvd;
  logic [VW-1:0]     div_dvs;
  logic              div_done;
  logic [CAP_W-1:0]  div_quo;

  lrsa_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  lrsa_div #(
    .DW (DW),
    .VW (VW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quo      (div_quo)
  );

  // per-point factors
  logic [CW-1:0]    fo, fr;
  logic [E_DW-1:0]  dvd_e;
  logic [ACC_W-1:0] za;
  logic [CAP_W-1:0] term;

  assign fo    = (n_r > o_r) ? (n_r - o_r) : '0;
  assign fr    = (n_r > r_r) ? (n_r - r_r) : '0;
  assign dvd_e = {mul_prod[PW-1:0], {FB{1'b0}}};
  assign za    = z_r[ACC_W-1] ? (~z_r + ACC_W'(1)) : z_r;
  assign term  = (n_r > CW'(1)) ? div_quo : '0;

  // z and v update
  logic [SUM_W-1:0]  zt;
  logic [CAP_W:0]    vt;
  logic              z_fits;

  assign zt     = {{(SUM_W-ACC_W){z_r[ACC_W-1]}}, z_r}
                + SUM_W'({l_r, {FB{1'b0}}}) - SUM_W'(e_r);
  assign z_fits = (zt[SUM_W-1:ACC_W-1] == '0) || (zt[SUM_W-1:ACC_W-1] == '1);
  assign vt     = (CAP_W+1)'(v_r) + (CAP_W+1)'(term);

  // unit operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MOR: begin
        mul_a = MUL_W'(o_r);
        mul_b = MUL_W'(r_r);
      end
      S_MNN: begin
        mul_a = MUL_W'(n_r);
        mul_b = MUL_W'(n_r - CW'(1));
      end
      S_MFF: begin
        mul_a = MUL_W'(fo);
        mul_b = MUL_W'(fr);
      end
      S_MEF: begin
        mul_a = MUL_W'(e_r);
        mul_b = MUL_W'(ff_r);
      end
      S_MZZ: begin
        mul_a = MUL_W'(za);
        mul_b = MUL_W'(za);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    div_dvd = '0;
    div_dvs = '0;
    div_ctl = '0;
    case (state_r)
      S_DE: begin
        div_dvd       = DW'(dvd_e);
        div_dvs       = VW'(n_r);
        div_ctl.nbits = NBITS_W'(E_DW);
      end
      S_DT: begin
        div_dvd       = mul_prod[DW-1:0];
        div_dvs       = VW'(nn_r);
        div_ctl.nbits = NBITS_W'(CAP_W + PW);
      end
      S_DS: begin
        div_dvd       = mul_prod[DW-1:0];
        div_dvs       = VW'(v_r);
        div_ctl.nbits = NBITS_W'(2 * SCORE_W);
        div_ctl.cap48 = 1'b1;
      end
      default: begin
        div_dvd = '0;
        div_dvs = '0;
      end
    endcase
    div_ctl.start = !launched_r && ((state_r == S_DE) || (state_r == S_DT) || (state_r == S_DS));
  end

  assign mul_start = !launched_r && ((state_r == S_MOR) || (state_r == S_MNN) ||
                                     (state_r == S_MFF) || (state_r == S_MEF) ||
                                     (state_r == S_MZZ));

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    launched_nxt   = launched_r;
    o_nxt          = o_r;
    n_nxt          = n_r;
    l_nxt          = l_r;
    r_nxt          = r_r;
    last_nxt       = last_r;
    e_nxt          = e_r;
    nn_nxt         = nn_r;
    ff_nxt         = ff_r;
    z_nxt          = z_r;
    v_nxt          = v_r;
    zv_nxt         = zv_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;

    if (mul_start || div_ctl.start) begin
      launched_nxt = 1'b1;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          o_nxt    = o_in;
          n_nxt    = n_in;
          l_nxt    = l_in;
          r_nxt    = r_in;
          last_nxt = in_tlast;
          // a final point with at most one failure adds no term
          if (in_tlast && !(o_in > CW'(1))) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_MOR;
          end
        end
      end
      S_MOR: begin
        if (mul_done) begin
          launched_nxt = 1'b0;
          if (n_r == '0) begin
            e_nxt     = '0;
            state_nxt = S_UPD;
          end else begin
            state_nxt = S_DE;
          end
        end
      end
      S_DE: begin
        if (div_done) begin
          launched_nxt = 1'b0;
          e_nxt        = div_quo;
          state_nxt    = (n_r > CW'(1)) ? S_MNN : S_UPD;
        end
      end
      S_MNN: begin
        if (mul_done) begin
          launched_nxt = 1'b0;
          nn_nxt       = mul_prod[PW-1:0];
          state_nxt    = S_MFF;
        end
      end
      S_MFF: begin
        if (mul_done) begin
          launched_nxt = 1'b0;
          ff_nxt       = mul_prod[PW-1:0];
          state_nxt    = S_MEF;
        end
      end
      S_MEF: begin
        if (mul_done) begin
          launched_nxt = 1'b0;
          state_nxt    = S_DT;
        end
      end
      S_DT: begin
        if (div_done) begin
          launched_nxt = 1'b0;
          state_nxt    = S_UPD;
        end
      end
      S_UPD: begin
        if (z_fits) begin
          z_nxt = zt[ACC_W-1:0];
        end else begin
          z_nxt = zt[SUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        v_nxt     = (|vt[CAP_W:ACC_W]) ? {ACC_W{1'b1}} : vt[ACC_W-1:0];
        state_nxt = last_r ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        zv_nxt    = (v_r == '0);
        state_nxt = (v_r == '0) ? S_EMIT : S_MZZ;
      end
      S_MZZ: begin
        if (mul_done) begin
          launched_nxt = 1'b0;
          state_nxt    = S_DS;
        end
      end
      S_DS: begin
        if (div_done) begin
          launched_nxt = 1'b0;
          state_nxt    = S_EMIT;
        end
      end
      S_EMIT: begin
        // hold until the output register is free
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = zv_r ? '0 : div_quo[SCORE_W-1:0];
          out_tuser_nxt  = !zv_r;
          z_nxt          = '0;
          v_nxt          = '0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt    = S_IDLE;
        launched_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      launched_r   <= 1'b0;
      z_r          <= '0;
      v_r          <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      launched_r   <= launched_nxt;
      z_r          <= z_nxt;
      v_r          <= v_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    o_r         <= o_nxt;
    n_r         <= n_nxt;
    l_r         <= l_nxt;
    r_r         <= r_nxt;
    last_r      <= last_nxt;
    e_r         <= e_nxt;
    nn_r        <= nn_nxt;
    ff_r        <= ff_nxt;
    zv_r        <= zv_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// ===== dv/logrank_score_checker.sv =====
`timescale 1ns / 1ps
// Checker for the logrank score accumulator: watches both stream channels, predicts
// the score of each test and compares it with what the block sends. Depends on lrsa_pkg.
module logrank_score_checker import lrsa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [4*FIELD_W-1:0] in_tdata,   // total_events, total_at_risk, left_events, left_at_risk
  input  logic                 in_tlast,   // last_point
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [SCORE_W-1:0]   out_tdata,  // score
  input  logic [0:0]           out_tuser,  // score_valid
  output int                   mismatches,
  output int                   pending
);

  localparam int          FB          = FRAC_BITS_DEF;
  localparam logic [63:0] TERM_LIMIT  = (64'd1 << CAP_W) - 64'd1;
  localparam logic [63:0] V_LIMIT     = (64'd1 << ACC_W) - 64'd1;
  localparam logic [63:0] SCORE_LIMIT = (64'd1 << SCORE_W) - 64'd1;
  localparam longint      Z_HI        = (longint'(1) << (ACC_W - 1)) - 1;
  localparam longint      Z_LO        = -Z_HI - 1;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               valid;
  } score_t;

  logic signed [ACC_W-1:0] z_acc;   // observed minus expected left failures
  logic [ACC_W-1:0]        v_acc;   // hypergeometric variance
  score_t                  expected_scores[$];

  // floor(num / den), clamped at limit
  function automatic logic [63:0] clamped_quotient(input logic [127:0] num,
                                                   input logic [63:0]  den,
                                                   input logic [63:0]  limit);
    logic [127:0] q;
    if (den == 64'd0) return limit;
    q = num / {64'd0, den};
    return (q > {64'd0, limit}) ? limit : q[63:0];
  endfunction

  task automatic fold_time_point(input logic [FIELD_W-1:0] o, n, l, r);
    logic [63:0] on, nn, ln, rn, e, term, fo, fr, v;
    longint      z;
    on = 64'(o); nn = 64'(n); ln = 64'(l); rn = 64'(r);
    e = 64'd0;
    term = 64'd0;
    if (nn != 64'd0) e = clamped_quotient({64'd0, on * rn} << FB, nn, TERM_LIMIT);
    if (nn > 64'd1) begin
      fo = (nn > on) ? nn - on : 64'd0;
      fr = (nn > rn) ? nn - rn : 64'd0;
      term = clamped_quotient({64'd0, e} * {64'd0, fo * fr}, nn * (nn - 64'd1), TERM_LIMIT);
    end
    z = longint'(z_acc);
    z = z + $signed(ln << FB) - $signed(e);
    if (z > Z_HI) z = Z_HI;
    if (z < Z_LO) z = Z_LO;
    z_acc = z[ACC_W-1:0];
    v = {16'd0, v_acc} + term;
    if (v > V_LIMIT) v = V_LIMIT;
    v_acc = v[ACC_W-1:0];
  endtask

  always @(posedge clk) begin : watch
    score_t                got, want;
    logic [FIELD_W-1:0]    o, n, l, r;
    longint                z;
    logic [63:0]           za;
    if (!rst_n) begin
      z_acc = '0;
      v_acc = '0;
      expected_scores.delete();
      mismatches = 0;
      pending <= 0;
    end else begin
      // compare first: a score leaving now belongs to an earlier test
      if (out_tvalid && out_tready) begin
        got = '{score: out_tdata, valid: out_tuser[0]};
        if (expected_scores.size() == 0) begin
          $display("%0t: score expected none actual %h valid %0d", $time, got.score,
                   got.valid);
          mismatches++;
        end else begin
          want = expected_scores.pop_front();
          if (got.score !== want.score) begin
            $display("%0t: score expected %h actual %h", $time, want.score, got.score);
            mismatches++;
          end
          if (got.valid !== want.valid) begin
            $display("%0t: score_valid expected %0d actual %0d", $time, want.valid, got.valid);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        o = in_tdata[FIELD_W-1:0];
        n = in_tdata[2*FIELD_W-1:FIELD_W];
        l = in_tdata[3*FIELD_W-1:2*FIELD_W];
        r = in_tdata[4*FIELD_W-1:3*FIELD_W];
        if (!in_tlast) begin
          fold_time_point(o, n, l, r);
        end else begin
          // the final point counts only with more than one failure
          if (o > 1) fold_time_point(o, n, l, r);
          if (v_acc == '0) begin
            want = '{score: '0, valid: 1'b0};
          end else begin
            z = longint'(z_acc);
            za = (z < 0) ? -z : z;
            za = clamped_quotient({64'd0, za} * {64'd0, za}, {16'd0, v_acc}, SCORE_LIMIT);
            want = '{score: za[SCORE_W-1:0], valid: 1'b1};
          end
          expected_scores.push_back(want);
          z_acc = '0;
          v_acc = '0;
        end
      end
      pending <= expected_scores.size();
    end
  end

endmodule

// ===== dv/logrank_score_accumulator_core_test.sv =====
`timescale 1ns / 1ps
// Testbench top for logrank_score_accumulator_core: drives directed and random
// failure time points with random idling and gives the verdict. Depends on lrsa_pkg
// and logrank_score_checker.
module logrank_score_accumulator_core_test;
  import lrsa_pkg::*;

  localparam int POINTS    = 1900;
  localparam int CALM_TAIL = 150;   // final points sent without idling

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [4*FIELD_W-1:0] in_tdata = '0;
  logic                 in_tlast = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [SCORE_W-1:0]   out_tdata;
  logic [0:0]           out_tuser;

  int mismatches;
  int pending;
  int points_sent = 0;
  int hold_cycles = 0;
  bit idle_on = 1'b0;
  bit calm = 1'b0;

  always #5 clk = ~clk;

  logrank_score_accumulator_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  logrank_score_checker score_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // receiver: stall at random while idling is on, outside the calm tail
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else if (idle_on && !calm && $urandom_range(0, 2) == 0) begin
      hold_cycles <= $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_point(input logic [FIELD_W-1:0] o, n, l, r, input logic last);
    in_tdata <= {r, l, n, o};
    in_tlast <= last;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    points_sent++;
    if (points_sent > POINTS - CALM_TAIL) calm = 1'b1;
    if (idle_on && !calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // one test: a run of time points closed by the point marked last
  task automatic send_test();
    int          len, style, n_max;
    logic [15:0] o, n, l, r;
    len = $urandom_range(1, 12);
    style = $urandom_range(0, 9);
    n_max = (style < 5) ? 40 : 65535;
    for (int i = 0; i < len; i++) begin
      if (style == 9 || $urandom_range(0, 15) == 0) begin
        // noise: fields with no relation to each other
        o = 16'($urandom); n = 16'($urandom); l = 16'($urandom); r = 16'($urandom);
        if ($urandom_range(0, 3) == 0) n = 16'($urandom_range(0, 2));
      end else begin
        n = 16'($urandom_range(0, n_max));
        r = 16'($urandom_range(0, n));
        o = 16'($urandom_range(0, n));
        l = 16'($urandom_range(0, (o < r) ? o : r));
      end
      // close some tests with a point of one failure or none
      if (i == len - 1 && style == 8) o = 16'($urandom_range(0, 1));
      send_point(o, n, l, r, i == len - 1);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero at risk, at risk of one, failures above at risk, left at risk above total
    send_point(16'd5, 16'd0, 16'd3, 16'd7, 1'b0);
    send_point(16'd1, 16'd1, 16'd1, 16'd1, 1'b0);
    send_point(16'd9, 16'd4, 16'd2, 16'd3, 1'b0);
    send_point(16'd2, 16'd5, 16'd1, 16'd8, 1'b0);
    send_point(16'd3, 16'd20, 16'd2, 16'd10, 1'b1);
    // final point with a single failure adds no term
    send_point(16'd2, 16'd10, 16'd1, 16'd4, 1'b0);
    send_point(16'd1, 16'd8, 16'd0, 16'd3, 1'b1);
    // zero variance: lone empty final point, then a test with at-risk of one only
    send_point(16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
    send_point(16'd3, 16'd1, 16'd1, 16'd1, 1'b0);
    send_point(16'd1, 16'd1, 16'd0, 16'd1, 1'b1);
    // all-ones fields
    send_point(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_point(16'd2, 16'hFFFF, 16'd1, 16'd1, 1'b0);
    send_point(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    // drive Z to its negative limit so the score saturates
    send_point(16'hFFFF, 16'd1, 16'd0, 16'hFFFF, 1'b0);
    send_point(16'hFFFF, 16'd1, 16'd0, 16'hFFFF, 1'b0);
    send_point(16'd2, 16'd4, 16'd0, 16'd2, 1'b1);
    // large left failures with nobody at risk push Z up
    send_point(16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 1'b0);
    send_point(16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 1'b0);
    send_point(16'd3, 16'd6, 16'd3, 16'd3, 1'b1);

    while (points_sent < POINTS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      send_test();
    end
    idle_on = 1'b0;
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("logrank_score_accumulator_core: match");
    end else begin
      $display("logrank_score_accumulator_core: mismatch");
    end
    $finish;
  end

  initial begin
    #25_000_000;
    $display("logrank_score_accumulator_core: mismatch");
    $finish;
  end

endmodule
